/* design/ppd_pkg.sv */
// Shared types and constants for the packed pixmap decoder.
package ppd_pkg;

   // Largest accepted image width and height.
   localparam int MaxDim = 4096;

   // Configuration port geometry.
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 16;

   // Result kinds.
   typedef enum logic [1:0] {
      KIND_PIXEL   = 2'd0,
      KIND_PALETTE = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   // Input item actions.
   localparam logic ACT_DATA  = 1'b0;
   localparam logic ACT_ENTRY = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CsrIndexW-1:0] {
      REG_HEADER_VALID   = 3'd0,
      REG_RAW_ROW_BYTES  = 3'd1,
      REG_IMAGE_WIDTH    = 3'd2,
      REG_IMAGE_HEIGHT   = 3'd3,
      REG_PIXEL_DEPTH    = 3'd4,
      REG_PIXMAP_VERSION = 3'd5,
      REG_PACK_KIND      = 3'd6
   } csr_reg_type;

   // Decoded header, as seen by the datapath.
   typedef struct packed {
      logic        ok;
      logic [1:0]  depth_log;
      logic [12:0] width;
      logic [12:0] height;
      logic [13:0] stride;
   } hdr_type;

   // One unit of work handed from the front end to the emitter.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic [11:0] x_base;
      logic [3:0]  count;
      logic [11:0] row;
      logic        last_row;
      logic [7:0]  slot;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } job_type;

   // One result item.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  pixel_value;
      logic [11:0] pixel_column;
      logic [11:0] pixel_row;
      logic [7:0]  palette_slot;
      logic [7:0]  slot_red;
      logic [7:0]  slot_green;
      logic [7:0]  slot_blue;
      logic        image_complete;
      logic        last_of_run;
   } rsp_type;

endpackage

/* design/ppd_hdr_check.sv */
// Header validation and decode of the pixmap configuration registers.
module ppd_hdr_check (
   input  logic                 header_valid,
   input  logic [15:0]          raw_row_bytes,
   input  logic signed [15:0]   image_width,
   input  logic signed [15:0]   image_height,
   input  logic signed [15:0]   pixel_depth,
   input  logic signed [15:0]   pixmap_version,
   input  logic signed [15:0]   pack_kind,
   output ppd_pkg::hdr_type     hdr
);

   logic signed [15:0] max_dim_s;
   logic               width_ok;
   logic               height_ok;
   logic               depth_ok;
   logic [1:0]         depth_log;
   logic [15:0]        row_bits;
   logic [16:0]        row_bits_round;
   logic [13:0]        need_bytes;
   logic               stride_ok;

   assign max_dim_s = 16'(ppd_pkg::MaxDim);

   // Size limits on the bounds rectangle.
   assign width_ok  = (image_width >= 16'sd1) && (image_width <= max_dim_s);
   assign height_ok = (image_height >= 16'sd1) && (image_height <= max_dim_s);

   // Only power-of-two depths up to a byte are supported.
   always_comb begin
      depth_ok  = 1'b1;
      depth_log = 2'd0;
      case (pixel_depth)
         16'sd1: depth_log = 2'd0;
         16'sd2: depth_log = 2'd1;
         16'sd4: depth_log = 2'd2;
         16'sd8: depth_log = 2'd3;
         default: begin
            depth_ok  = 1'b0;
            depth_log = 2'd0;
         end
      endcase
   end

   // The stride must hold one row of pixels, rounded up to whole bytes.
   assign row_bits       = {3'd0, image_width[12:0]} << depth_log;
   assign row_bits_round = {1'b0, row_bits} + 17'd7;
   assign need_bytes     = row_bits_round[16:3];
   assign stride_ok      = raw_row_bytes[13:0] >= need_bytes;

   always_comb begin
      hdr.ok        = header_valid && (raw_row_bytes[15:14] == 2'b10) && width_ok &&
                      height_ok && (pixmap_version == 16'sd0) && (pack_kind == 16'sd0) &&
                      depth_ok && stride_ok;
      hdr.depth_log = depth_log;
      hdr.width     = image_width[12:0];
      hdr.height    = image_height[12:0];
      hdr.stride    = raw_row_bytes[13:0];
   end

endmodule

/* design/ppd_front.sv */
// Front end: row and column tracking and decode of each input item into a job.
module ppd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                req_action,
   input  logic [7:0]          req_data_byte,
   input  logic signed [15:0]  req_entry_index,
   input  logic [7:0]          req_entry_red,
   input  logic [7:0]          req_entry_green,
   input  logic [7:0]          req_entry_blue,
   input  ppd_pkg::hdr_type    hdr,
   output ppd_pkg::job_type    job,
   output logic                job_load
);

   logic [13:0] byte_column_ff, byte_column_in;
   logic [12:0] current_row_ff, current_row_in;
   logic        rows_finished_ff, rows_finished_in;

   logic [1:0]  per_log;
   logic [3:0]  per_byte;
   logic [16:0] x_base;
   logic [16:0] remain;
   logic        in_image;
   logic        at_end;
   logic [14:0] col_next;
   logic        row_end;
   logic [12:0] row_next;
   logic        has_result;

   // Pixels per byte and the first pixel column of this byte.
   assign per_log  = 2'd3 - hdr.depth_log;
   assign per_byte = 4'd1 << per_log;
   assign x_base   = {3'd0, byte_column_ff} << per_log;
   assign in_image = x_base < {4'd0, hdr.width};
   assign remain   = {4'd0, hdr.width} - x_base;

   assign at_end   = rows_finished_ff || (current_row_ff >= hdr.height);
   assign col_next = {1'b0, byte_column_ff} + 15'd1;
   assign row_end  = col_next >= {1'b0, hdr.stride};
   assign row_next = current_row_ff + 13'd1;

   // Build the job for the item on the request port.
   always_comb begin
      job        = '0;
      has_result = 1'b0;
      if (!hdr.ok) begin
         job.kind   = ppd_pkg::KIND_ERROR;
         has_result = 1'b1;
      end else if (req_action == ppd_pkg::ACT_ENTRY) begin
         job.kind   = ppd_pkg::KIND_PALETTE;
         job.slot   = req_entry_index[7:0];
         job.red    = req_entry_red;
         job.green  = req_entry_green;
         job.blue   = req_entry_blue;
         has_result = (req_entry_index[15:8] == 8'd0);
      end else begin
         job.kind     = ppd_pkg::KIND_PIXEL;
         job.data     = req_data_byte;
         job.x_base   = x_base[11:0];
         job.count    = (remain < {13'd0, per_byte}) ? remain[3:0] : per_byte;
         job.row      = current_row_ff[11:0];
         job.last_row = (current_row_ff == (hdr.height - 13'd1));
         has_result   = !at_end && in_image;
      end
   end

   assign job_load = accept && has_result;

   // Advance the byte position on every transfer of a pixel data byte under a valid header.
   always_comb begin
      byte_column_in   = byte_column_ff;
      current_row_in   = current_row_ff;
      rows_finished_in = rows_finished_ff;
      if (accept && hdr.ok && (req_action == ppd_pkg::ACT_DATA)) begin
         if (at_end) begin
            rows_finished_in = 1'b1;
         end else if (row_end) begin
            byte_column_in = '0;
            current_row_in = row_next;
            if (row_next >= hdr.height) begin
               rows_finished_in = 1'b1;
            end
         end else begin
            byte_column_in = col_next[13:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_column_ff   <= '0;
         current_row_ff   <= '0;
         rows_finished_ff <= 1'b0;
      end else begin
         byte_column_ff   <= byte_column_in;
         current_row_ff   <= current_row_in;
         rows_finished_ff <= rows_finished_in;
      end
   end

endmodule

/* design/ppd_emit.sv */
// Emitter: holds one job; its results enter the result register one per unstalled cycle.
module ppd_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                job_load,
   input  ppd_pkg::job_type    job,
   input  ppd_pkg::hdr_type    hdr,
   output logic                load_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ppd_pkg::rsp_type    rsp
);

   logic              busy_ff, busy_in;
   ppd_pkg::job_type  job_ff, job_in;
   logic [2:0]        step_ff, step_in;
   logic [7:0]        shift_ff, shift_in;
   logic              out_valid_ff, out_valid_in;
   ppd_pkg::rsp_type  out_ff, out_in;

   logic              advance;
   logic              is_last;
   logic [11:0]       column;
   logic [7:0]        shifted;
   ppd_pkg::rsp_type  result;

   // A result moves on whenever the result register is free or being emptied.
   assign advance    = busy_ff && (!out_valid_ff || rsp_ready);
   assign is_last    = (job_ff.kind != ppd_pkg::KIND_PIXEL) ||
                       ({1'b0, step_ff} == (job_ff.count - 4'd1));
   assign load_ready = !busy_ff || (advance && is_last);
   assign column     = job_ff.x_base + {9'd0, step_ff};

   // Current pixel sits in the top bits; the next one follows after a shift.
   always_comb begin
      case (hdr.depth_log)
         2'd0: shifted = {shift_ff[6:0], 1'b0};
         2'd1: shifted = {shift_ff[5:0], 2'b0};
         2'd2: shifted = {shift_ff[3:0], 4'b0};
         2'd3: shifted = 8'd0;
         default: shifted = 8'd0;
      endcase
   end

   // Format the result of the current step.
   always_comb begin
      result             = '0;
      result.kind        = job_ff.kind;
      result.last_of_run = is_last;
      case (job_ff.kind)
         ppd_pkg::KIND_PIXEL: begin
            case (hdr.depth_log)
               2'd0: result.pixel_value = {7'd0, shift_ff[7]};
               2'd1: result.pixel_value = {6'd0, shift_ff[7:6]};
               2'd2: result.pixel_value = {4'd0, shift_ff[7:4]};
               2'd3: result.pixel_value = shift_ff;
               default: result.pixel_value = 8'd0;
            endcase
            result.pixel_column   = column;
            result.pixel_row      = job_ff.row;
            result.image_complete = job_ff.last_row &&
                                    ({1'b0, column} == (hdr.width - 13'd1));
         end
         ppd_pkg::KIND_PALETTE: begin
            result.palette_slot = job_ff.slot;
            result.slot_red     = job_ff.red;
            result.slot_green   = job_ff.green;
            result.slot_blue    = job_ff.blue;
         end
         default: begin
            result.last_of_run = 1'b1;
         end
      endcase
   end

   // Job register and step counter.
   always_comb begin
      busy_in  = busy_ff;
      job_in   = job_ff;
      step_in  = step_ff;
      shift_in = shift_ff;
      if (job_load) begin
         busy_in  = 1'b1;
         job_in   = job;
         step_in  = '0;
         shift_in = job.data;
      end else if (advance && is_last) begin
         busy_in = 1'b0;
      end else if (advance) begin
         step_in  = step_ff + 3'd1;
         shift_in = shifted;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_in       = result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff   <= job_in;
      step_ff  <= step_in;
      shift_ff <= shift_in;
      out_ff   <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

/* design/packed_pixmap_decoder.sv */
// Top level of the packed pixmap decoder: configuration registers and datapath.
//
// Decodes an indexed pixmap: the header lives in seven configuration registers, and
// each input transfer is either one packed pixel data byte or one colour table entry.
// A data byte expands into up to 8/depth pixel results, a valid colour entry into one
// palette write, and every item under a bad header into one format error. Results
// leave one per cycle from a single emitter unless the result side stalls; a data byte
// gives one result per visible pixel (1 to 8 at depth 1, 1 to 4 at depth 2, 1 to 2 at
// depth 4, 1 at depth 8), and palette writes and errors one each. Items that produce
// nothing (padding bytes, data past the last row, out-of-range colour indexes) are
// absorbed at one per cycle while the emitter can take a job. With the result side
// always ready, a single-result item follows its predecessor in the next cycle; an
// item's first result passes the job register, then the result register.
// Configuration must only be written while no results are outstanding.
module packed_pixmap_decoder (
   input  logic                clock,
   input  logic                reset,
   // Request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_action,
   input  logic [7:0]          req_data_byte,
   input  logic signed [15:0]  req_entry_index,
   input  logic [7:0]          req_entry_red,
   input  logic [7:0]          req_entry_green,
   input  logic [7:0]          req_entry_blue,
   // Result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_kind,
   output logic [7:0]          rsp_pixel_value,
   output logic [11:0]         rsp_pixel_column,
   output logic [11:0]         rsp_pixel_row,
   output logic [7:0]          rsp_palette_slot,
   output logic [7:0]          rsp_slot_red,
   output logic [7:0]          rsp_slot_green,
   output logic [7:0]          rsp_slot_blue,
   output logic                rsp_image_complete,
   output logic                rsp_last_of_run,
   // Configuration write port
   input  logic                                csr_write_en,
   input  logic [ppd_pkg::CsrIndexW-1:0]      csr_index,
   input  logic [ppd_pkg::CsrDataW-1:0]       csr_wdata
);

   logic        header_valid_ff;
   logic [15:0] raw_row_bytes_ff;
   logic [15:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [15:0] pixel_depth_ff;
   logic [15:0] pixmap_version_ff;
   logic [15:0] pack_kind_ff;

   ppd_pkg::hdr_type hdr;
   ppd_pkg::job_type job;
   ppd_pkg::rsp_type rsp;
   logic             job_load;
   logic             load_ready;
   logic             accept;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_valid_ff   <= 1'b0;
         raw_row_bytes_ff  <= '0;
         image_width_ff    <= '0;
         image_height_ff   <= '0;
         pixel_depth_ff    <= '0;
         pixmap_version_ff <= '0;
         pack_kind_ff      <= '0;
      end else if (csr_write_en) begin
         case (ppd_pkg::csr_reg_type'(csr_index))
            ppd_pkg::REG_HEADER_VALID:   header_valid_ff   <= csr_wdata[0];
            ppd_pkg::REG_RAW_ROW_BYTES:  raw_row_bytes_ff  <= csr_wdata;
            ppd_pkg::REG_IMAGE_WIDTH:    image_width_ff    <= csr_wdata;
            ppd_pkg::REG_IMAGE_HEIGHT:   image_height_ff   <= csr_wdata;
            ppd_pkg::REG_PIXEL_DEPTH:    pixel_depth_ff    <= csr_wdata;
            ppd_pkg::REG_PIXMAP_VERSION: pixmap_version_ff <= csr_wdata;
            ppd_pkg::REG_PACK_KIND:      pack_kind_ff      <= csr_wdata;
            default: ;
         endcase
      end
   end

   ppd_hdr_check u_hdr_check (
      .header_valid   (header_valid_ff),
      .raw_row_bytes  (raw_row_bytes_ff),
      .image_width    ($signed(image_width_ff)),
      .image_height   ($signed(image_height_ff)),
      .pixel_depth    ($signed(pixel_depth_ff)),
      .pixmap_version ($signed(pixmap_version_ff)),
      .pack_kind      ($signed(pack_kind_ff)),
      .hdr            (hdr)
   );

   // A request transfers whenever the emitter can take a new job.
   assign req_ready = load_ready;
   assign accept    = req_valid && req_ready;

   ppd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .req_entry_index (req_entry_index),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .hdr             (hdr),
      .job             (job),
      .job_load        (job_load)
   );

   ppd_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .job_load   (job_load),
      .job        (job),
      .hdr        (hdr),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

   // Result fields.
   assign rsp_kind           = rsp.kind;
   assign rsp_pixel_value    = rsp.pixel_value;
   assign rsp_pixel_column   = rsp.pixel_column;
   assign rsp_pixel_row      = rsp.pixel_row;
   assign rsp_palette_slot   = rsp.palette_slot;
   assign rsp_slot_red       = rsp.slot_red;
   assign rsp_slot_green     = rsp.slot_green;
   assign rsp_slot_blue      = rsp.slot_blue;
   assign rsp_image_complete = rsp.image_complete;
   assign rsp_last_of_run    = rsp.last_of_run;

endmodule

/* design/ppd_checker.sv */
// Port-level assertions for the packed pixmap decoder, bound to the top level.
module ppd_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [1:0]                     rsp_kind,
   input  logic [7:0]                     rsp_pixel_value,
   input  logic [11:0]                    rsp_pixel_column,
   input  logic [11:0]                    rsp_pixel_row,
   input  logic [7:0]                     rsp_palette_slot,
   input  logic [7:0]                     rsp_slot_red,
   input  logic [7:0]                     rsp_slot_green,
   input  logic [7:0]                     rsp_slot_blue,
   input  logic                           rsp_image_complete,
   input  logic                           rsp_last_of_run
);

   // A stalled result holds its value until it transfers.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_pixel_value) && $stable(rsp_pixel_column) && $stable(rsp_pixel_row) &&
      $stable(rsp_palette_slot) && $stable(rsp_slot_red) && $stable(rsp_slot_green) &&
      $stable(rsp_slot_blue) && $stable(rsp_image_complete) && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // A format error is a single, otherwise empty result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ppd_pkg::KIND_ERROR) |->
      rsp_last_of_run && (rsp_pixel_value == 8'd0) && (rsp_pixel_column == 12'd0) &&
      (rsp_palette_slot == 8'd0) && !rsp_image_complete)
      else $error("format error result carries payload");

   // The final pixel of the image is always the last pixel of its byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_image_complete |->
      (rsp_kind == ppd_pkg::KIND_PIXEL) && rsp_last_of_run)
      else $error("image completion on a non-final result");

   // Palette writes carry no pixel position.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == ppd_pkg::KIND_PALETTE) |->
      rsp_last_of_run && (rsp_pixel_column == 12'd0) && (rsp_pixel_row == 12'd0))
      else $error("palette write with pixel fields set");

endmodule

bind packed_pixmap_decoder ppd_checker u_ppd_checker (.*);
